// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is low.
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
    `CHK_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== hw/rtl/plip_pkg.sv =====
// Shared types, constants and codes of the posting list intersection probe.
`default_nettype none
package plip_pkg;

    localparam int MAX_TERMS_DEF  = 10;
    localparam int LIST_DEPTH_DEF = 1024;

    localparam int CMD_W = 2;
    localparam int SEL_W = 4;
    localparam int ID_W  = 32;
    localparam int TC_W  = 4;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [SEL_W-1:0] t_list_sel;
    typedef logic [ID_W-1:0]  t_doc_id;
    typedef logic [TC_W-1:0]  t_tc;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_PROBE  = 2'd2
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIST,
        ST_CHECK,
        ST_CMP,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input beat accepted this cycle
        logic list_begin;  // restart element index for the current list
        logic rd;          // read list element at (slot, idx)
        logic idx_inc;     // step to next element
        logic slot_inc;    // hit: step to next list
        logic miss;        // probe failed
        logic finish;      // load result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_probe;    // input beat carries a probe
        logic lists_done;  // no stored list left in the query
        logic idx_end;     // index ran past the list length
        logic id_lt;       // probe id below the element read
        logic id_eq;       // probe id equal to the element read
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/plip_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none
interface plip_req_if;
    logic                valid;
    logic                ready;
    plip_pkg::t_cmd      cmd;
    plip_pkg::t_list_sel list_sel;
    plip_pkg::t_doc_id   doc_id;

    modport source (output valid, output cmd, output list_sel, output doc_id, input ready);
    modport sink   (input valid, input cmd, input list_sel, input doc_id, output ready);
endinterface

interface plip_res_if;
    logic              valid;
    logic              ready;
    plip_pkg::t_doc_id probe_id;
    logic              in_all;

    modport source (output valid, output probe_id, output in_all, input ready);
    modport sink   (input valid, input probe_id, input in_all, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/posting_list_intersection_probe.sv =====
// Top level of the posting list intersection probe: controller, datapath, checks.
`default_nettype none
`include "assert_macros.svh"
// Stores up to MAX_TERMS-1 posting lists of up to LIST_DEPTH document ids each
// in one on-chip RAM (list k at rows (k-1)*LIST_DEPTH onward) and answers, for
// each probe id, whether that id is present in every stored list 1..term_count-1.
// Clear and append beats are taken while the sequencer stays idle: the input is
// ready again in the next cycle. A probe is handled one at a time by a sequencer
// that walks the lists in order and, within a list, the elements from the first,
// stopping at the first element greater than or equal to the id; the scan of the
// whole probe stops at the first list that misses. Each element is a RAM read
// (ST_CHECK), then a compare against the registered read data (ST_CMP); each
// list starts in ST_LIST; the probe is accepted in ST_IDLE and its result is
// loaded from ST_DONE. A term_count of 0 or 1 answers 1 without reading the
// store. Results sit in an output register, so the next beat is accepted while
// a result waits; a finished probe holds the sequencer until that register
// frees. The input stays closed while reset is held. The list store has no
// reset: only entries below a list's length are ever read. term_count (written
// through i_cfg_we/i_cfg_wdata, reset 1, clamped to MAX_TERMS) must only change
// while no probe is in flight.
module posting_list_intersection_probe #(
    parameter int MAX_TERMS  = plip_pkg::MAX_TERMS_DEF,
    parameter int LIST_DEPTH = plip_pkg::LIST_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire plip_pkg::t_tc i_cfg_wdata,
    plip_req_if.sink           i_req,
    plip_res_if.source         o_res
);
    import plip_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    assign i_req.ready = w_ready;

    plip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    plip_dp #(
        .MAX_TERMS  (MAX_TERMS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (i_req.cmd),
        .i_list_sel     (i_req.list_sel),
        .i_doc_id       (i_req.doc_id),
        .i_ctl          (w_cmd),
        .o_sts          (w_sts),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_res_probe_id (o_res.probe_id),
        .o_res_in_all   (o_res.in_all)
    );

    // A beat is never taken in the same cycle a result is loaded.
    `CHK_NEVER(a_take_vs_finish, i_clk, i_rst_n, w_cmd.take && w_cmd.finish, "take during finish")
    // A probe beat closes the input until its result is loaded.
    `CHK_PROP(a_probe_blocks, i_clk, i_rst_n, (i_req.valid && i_req.ready && (i_req.cmd == CMD_PROBE)) |=> !i_req.ready, "ready after probe")
    // A result only lands in a free output register.
    `CHK_PROP(a_finish_free, i_clk, i_rst_n, w_cmd.finish |-> (!o_res.valid || o_res.ready), "result overwrites pending beat")
    // The store is only read inside the current list's length.
    `CHK_PROP(a_read_in_range, i_clk, i_rst_n, w_cmd.rd |-> !w_sts.idx_end, "read past list end")

endmodule
`default_nettype wire

// ===== hw/rtl/plip_ram.sv =====
// Generic simple dual port RAM, one write port, one registered read port.
`default_nettype none
module plip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== hw/rtl/plip_ctrl.sv =====
// Probe sequencer: walks lists and elements, drives the datapath.
`default_nettype none
module plip_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire plip_pkg::t_dp_sts i_sts,
    output plip_pkg::t_dp_cmd      o_cmd
);
    import plip_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // closed while reset is held
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.is_probe) begin
                        n_state = ST_LIST;
                    end
                end
            end
            ST_LIST: begin
                if (i_sts.lists_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.list_begin = 1'b1;
                    n_state          = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.idx_end) begin
                    o_cmd.miss = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.id_lt) begin
                    o_cmd.miss = 1'b1;
                    n_state    = ST_DONE;
                end else if (i_sts.id_eq) begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = ST_LIST;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/plip_dp.sv =====
// Datapath: list store, list lengths, scan pointers, compare, result register.
`default_nettype none
module plip_dp #(
    parameter int MAX_TERMS  = plip_pkg::MAX_TERMS_DEF,
    parameter int LIST_DEPTH = plip_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire plip_pkg::t_tc       i_cfg_wdata,
    input  wire plip_pkg::t_cmd      i_cmd,
    input  wire plip_pkg::t_list_sel i_list_sel,
    input  wire plip_pkg::t_doc_id   i_doc_id,
    input  wire plip_pkg::t_dp_cmd   i_ctl,
    output plip_pkg::t_dp_sts        o_sts,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output plip_pkg::t_doc_id        o_res_probe_id,
    output logic                     o_res_in_all
);
    import plip_pkg::*;

    localparam int NUM_STORED = MAX_TERMS - 1;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int SLOT_W     = $clog2(MAX_TERMS);
    localparam int SIDX_W     = (NUM_STORED > 1) ? $clog2(NUM_STORED) : 1;
    localparam int MEM_DEPTH  = NUM_STORED * LIST_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    t_tc               r_tc;
    logic [LEN_W-1:0]  r_len [NUM_STORED];
    t_doc_id           r_id;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_idx;
    logic              r_all;
    logic              r_out_valid;
    t_doc_id           r_out_id;
    logic              r_out_all;

    logic [SEL_W:0]    w_sel_ext;
    logic              w_sel_ok;
    t_list_sel         w_sel_m1;
    logic [SIDX_W-1:0] w_in_slot;
    logic [SIDX_W-1:0] w_len_idx;
    logic [LEN_W-1:0]  w_len;
    logic              w_full;
    logic              w_do_clear;
    logic              w_do_append;
    logic [TC_W:0]     w_tc_cl;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    t_doc_id           w_rdata;

    // list select decode
    assign w_sel_ext = {1'b0, i_list_sel};
    assign w_sel_ok  = (w_sel_ext != '0) && (w_sel_ext < (SEL_W+1)'(MAX_TERMS));
    assign w_sel_m1  = i_list_sel - SEL_W'(1);
    assign w_in_slot = w_sel_m1[SIDX_W-1:0];

    // one length read: input list on a command beat, scan list otherwise
    assign w_len_idx = i_ctl.take ? w_in_slot : r_slot[SIDX_W-1:0];
    assign w_len     = r_len[w_len_idx];
    assign w_full    = (w_len >= LEN_W'(LIST_DEPTH));

    always_comb begin
        w_do_clear  = 1'b0;
        w_do_append = 1'b0;
        unique case (i_cmd)
            CMD_CLEAR:  w_do_clear  = i_ctl.take && w_sel_ok;
            CMD_APPEND: w_do_append = i_ctl.take && w_sel_ok && !w_full;
            default:    ;
        endcase
    end

    assign w_tc_cl = ({1'b0, r_tc} > (TC_W+1)'(MAX_TERMS)) ? (TC_W+1)'(MAX_TERMS)
                                                            : {1'b0, r_tc};

    assign w_waddr = ADDR_W'(w_in_slot) * ADDR_W'(LIST_DEPTH) + ADDR_W'(w_len[IDX_W-1:0]);
    assign w_raddr = ADDR_W'(r_slot[SIDX_W-1:0]) * ADDR_W'(LIST_DEPTH)
                   + ADDR_W'(r_idx[IDX_W-1:0]);

    plip_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_do_append),
        .i_waddr (w_waddr),
        .i_wdata (i_doc_id),
        .i_re    (i_ctl.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= TC_W'(1);
            for (int k = 0; k < NUM_STORED; k++) begin
                r_len[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tc <= i_cfg_wdata;
            end
            if (w_do_clear) begin
                r_len[w_in_slot] <= '0;
            end else if (w_do_append) begin
                r_len[w_in_slot] <= w_len + LEN_W'(1);
            end
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan pointers and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && o_sts.is_probe) begin
            r_id   <= i_doc_id;
            r_slot <= '0;
            r_all  <= 1'b1;
        end
        if (i_ctl.list_begin) begin
            r_idx <= '0;
        end
        if (i_ctl.idx_inc) begin
            r_idx <= r_idx + LEN_W'(1);
        end
        if (i_ctl.slot_inc) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
        if (i_ctl.miss) begin
            r_all <= 1'b0;
        end
        if (i_ctl.finish) begin
            r_out_id  <= r_id;
            r_out_all <= r_all;
        end
    end

    assign o_sts.is_probe   = (i_cmd == CMD_PROBE);
    assign o_sts.lists_done = ((TC_W+1)'(r_slot) + (TC_W+1)'(1)) >= w_tc_cl;
    assign o_sts.idx_end    = (r_idx >= w_len);
    assign o_sts.id_lt      = (r_id < w_rdata);
    assign o_sts.id_eq      = (r_id == w_rdata);
    assign o_sts.out_free   = !r_out_valid || i_res_ready;

    assign o_res_valid    = r_out_valid;
    assign o_res_probe_id = r_out_id;
    assign o_res_in_all   = r_out_all;
endmodule
`default_nettype wire
